### design/assert_macros.svh
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic property check, disabled while reset is asserted.
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: when ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### design/egcd_pkg.sv
// Package for the extended gcd block: width default and sequencer states.
`timescale 1ns / 1ps

package egcd_pkg;

  localparam int unsigned WORD_BITS = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_FINISH
  } egcd_state_e;

endpackage

### design/egcd_in_if.sv
// Request channel interface: two signed operands as magnitude plus sign.
`timescale 1ns / 1ps

interface egcd_in_if #(
  parameter int unsigned WordBits = egcd_pkg::WORD_BITS
);
  logic                valid;
  logic                ready;
  logic [WordBits-1:0] a_mag;
  logic                a_neg;
  logic [WordBits-1:0] b_mag;
  logic                b_neg;

  modport source (output valid, a_mag, a_neg, b_mag, b_neg, input ready);
  modport sink   (input valid, a_mag, a_neg, b_mag, b_neg, output ready);
endinterface

### design/egcd_out_if.sv
// Result channel interface: gcd, Bezout coefficients and cofactors.
`timescale 1ns / 1ps

interface egcd_out_if #(
  parameter int unsigned WordBits = egcd_pkg::WORD_BITS
);
  logic                valid;
  logic                ready;
  logic [WordBits-1:0] gcd_value;
  logic [WordBits-1:0] s_mag;
  logic                s_neg;
  logic [WordBits-1:0] t_mag;
  logic                t_neg;
  logic [WordBits-1:0] qa_mag;
  logic                qa_neg;
  logic [WordBits-1:0] qb_mag;
  logic                qb_neg;

  modport source (output valid, gcd_value, s_mag, s_neg, t_mag, t_neg,
                  qa_mag, qa_neg, qb_mag, qb_neg, input ready);
  modport sink   (input valid, gcd_value, s_mag, s_neg, t_mag, t_neg,
                  qa_mag, qa_neg, qb_mag, qb_neg, output ready);
endinterface

### design/egcd_divstep.sv
// One restoring-division step fused with Horner accumulation of q times each coefficient.
`timescale 1ns / 1ps

module egcd_divstep #(
  parameter int unsigned WordBits = egcd_pkg::WORD_BITS
) (
  input  logic [WordBits-1:0] part_i,
  input  logic                dvd_msb_i,
  input  logic [WordBits-1:0] dvs_i,
  input  logic [WordBits:0]   hb_i,
  input  logic [WordBits:0]   ha_i,
  input  logic [WordBits:0]   cqb_i,
  input  logic [WordBits:0]   cqa_i,
  output logic [WordBits-1:0] part_o,
  output logic                qbit_o,
  output logic [WordBits:0]   hb_o,
  output logic [WordBits:0]   ha_o
);

  logic [WordBits:0]   shifted;
  logic [WordBits+1:0] diff;

  assign shifted = {part_i, dvd_msb_i};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_i};
  assign qbit_o  = ~diff[WordBits+1];
  assign part_o  = qbit_o ? diff[WordBits-1:0] : shifted[WordBits-1:0];
  assign hb_o    = {hb_i[WordBits-1:0], 1'b0} + (qbit_o ? cqb_i : '0);
  assign ha_o    = {ha_i[WordBits-1:0], 1'b0} + (qbit_o ? cqa_i : '0);

endmodule

### design/extended_gcd_single_word_top.sv
// R = number of Euclid rounds per request (up to ~46 at 32 bits).
// Each round runs one bit-serial division step per cycle, WordBits steps, plus check and update.
// The quotient times each coefficient is built alongside the division, so no extra passes.
// The next request is taken the cycle after the result is registered.
// A waiting result does not block the next request.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops the output valid.
`timescale 1ns / 1ps

module extended_gcd_single_word_top #(
  parameter int unsigned WordBits = egcd_pkg::WORD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  egcd_in_if.sink     req_i,
  egcd_out_if.source  rsp_o
);

  `include "assert_macros.svh"

  localparam int unsigned CW   = WordBits + 1;
  localparam int unsigned CntW = $clog2(WordBits);

  egcd_pkg::egcd_state_e state_q, state_d;

  logic [WordBits-1:0] ra_q, rb_q, part_q, dvd_q;
  logic [CW-1:0]       cs_q, ct_q, cqa_q, cqb_q, hb_q, ha_q;
  logic                sa_q, sb_q;
  logic [CntW-1:0]     cnt_q;

  logic [WordBits-1:0] part_nx;
  logic                qbit;
  logic [CW-1:0]       hb_nx, ha_nx;

  logic in_ready, div_start, div_step, upd, out_load, out_free, in_accept;
  logic out_valid_q;

  function automatic logic [WordBits:0] split_mag(input logic [CW-1:0] c);
    logic [CW-1:0] m;
    m = c[CW-1] ? (~c + CW'(1)) : c;
    return {c[CW-1], m[WordBits-1:0]};
  endfunction

  logic [WordBits:0] s_split, t_split, qa_split, qb_split;

  assign s_split  = split_mag(cs_q);
  assign t_split  = split_mag(ct_q);
  assign qa_split = split_mag(cqa_q);
  assign qb_split = split_mag(cqb_q);

  assign out_free  = ~out_valid_q | rsp_o.ready;
  assign in_accept = req_i.valid & in_ready;
  assign req_i.ready = in_ready;

  egcd_divstep #(.WordBits(WordBits)) u_divstep (
    .part_i    (part_q),
    .dvd_msb_i (dvd_q[WordBits-1]),
    .dvs_i     (rb_q),
    .hb_i      (hb_q),
    .ha_i      (ha_q),
    .cqb_i     (cqb_q),
    .cqa_i     (cqa_q),
    .part_o    (part_nx),
    .qbit_o    (qbit),
    .hb_o      (hb_nx),
    .ha_o      (ha_nx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      egcd_pkg::ST_IDLE:   if (req_i.valid) state_d = egcd_pkg::ST_CHECK;
      egcd_pkg::ST_CHECK:  state_d = (rb_q == '0) ? egcd_pkg::ST_FINISH : egcd_pkg::ST_DIV;
      egcd_pkg::ST_DIV:    if (cnt_q == CntW'(WordBits - 1)) state_d = egcd_pkg::ST_UPD;
      egcd_pkg::ST_UPD:    state_d = egcd_pkg::ST_CHECK;
      egcd_pkg::ST_FINISH: if (out_free) state_d = egcd_pkg::ST_IDLE;
      default:             state_d = egcd_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_step  = 1'b0;
    upd       = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      egcd_pkg::ST_IDLE:   in_ready  = 1'b1;
      egcd_pkg::ST_CHECK:  div_start = (rb_q != '0);
      egcd_pkg::ST_DIV:    div_step  = 1'b1;
      egcd_pkg::ST_UPD:    upd       = 1'b1;
      egcd_pkg::ST_FINISH: out_load  = out_free;
      default:             in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= egcd_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) begin
        cnt_q <= '0;
      end else if (div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ra_q  <= req_i.a_mag;
      rb_q  <= req_i.b_mag;
      sa_q  <= req_i.a_neg;
      sb_q  <= req_i.b_neg;
      cs_q  <= CW'(1);
      cqb_q <= '0;
      ct_q  <= '0;
      cqa_q <= CW'(1);
    end
    if (div_start) begin
      part_q <= '0;
      dvd_q  <= ra_q;
      hb_q   <= '0;
      ha_q   <= '0;
    end
    if (div_step) begin
      part_q <= part_nx;
      dvd_q  <= {dvd_q[WordBits-2:0], qbit};
      hb_q   <= hb_nx;
      ha_q   <= ha_nx;
    end
    if (upd) begin
      ra_q  <= rb_q;
      rb_q  <= part_q;
      cs_q  <= cqb_q;
      cqb_q <= cs_q - hb_q;
      ct_q  <= cqa_q;
      cqa_q <= ct_q - ha_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_o.gcd_value <= ra_q;
      rsp_o.s_mag     <= s_split[WordBits-1:0];
      rsp_o.s_neg     <= s_split[WordBits] ^ sa_q;
      rsp_o.t_mag     <= t_split[WordBits-1:0];
      rsp_o.t_neg     <= t_split[WordBits] ^ sb_q;
      rsp_o.qa_mag    <= qa_split[WordBits-1:0];
      rsp_o.qa_neg    <= sa_q;
      rsp_o.qb_mag    <= qb_split[WordBits-1:0];
      rsp_o.qb_neg    <= sb_q;
    end
  end

  assign rsp_o.valid = out_valid_q;

  `ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == egcd_pkg::ST_DIV, rb_q != '0, "divide by zero")
  `ASSERT_IMPL(a_rem_below, clk_i, rst_ni, state_q == egcd_pkg::ST_DIV, part_q < rb_q, "remainder not below divisor")
  `ASSERT_CHK(a_busy_after_req, clk_i, rst_ni, in_accept |=> !in_ready, "request taken while busy")
  `ASSERT_CHK(a_rsp_from_finish, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == egcd_pkg::ST_FINISH, "result raised outside finish")

endmodule
